[rtl/ssf_pkg.sv]
`timescale 1ns / 1ps
package ssf_pkg;

    localparam int unsigned FrameLen    = 25;
    localparam int unsigned PayloadLen  = 20;
    localparam int unsigned HeaderLen   = 3;
    localparam int unsigned FifoDepth   = 2;
    localparam int unsigned IdxW        = $clog2(FrameLen);
    localparam int unsigned PayIdxW     = $clog2(PayloadLen);

    localparam logic [7:0]  SyncFirst   = 8'hAA;
    localparam logic [7:0]  SyncSecond  = 8'h55;
    localparam logic [7:0]  LenByte     = 8'(PayloadLen);
    localparam logic [15:0] CrcPoly     = 16'hA001;
    localparam logic [15:0] CrcInit     = 16'hFFFF;

    // frame positions
    localparam logic [IdxW-1:0] IdxSync0   = IdxW'(0);
    localparam logic [IdxW-1:0] IdxSync1   = IdxW'(1);
    localparam logic [IdxW-1:0] IdxLen     = IdxW'(2);
    localparam logic [IdxW-1:0] IdxPayFirst = IdxW'(HeaderLen);
    localparam logic [IdxW-1:0] IdxPayLast = IdxW'(HeaderLen + PayloadLen - 1);
    localparam logic [IdxW-1:0] IdxCrcLo   = IdxW'(HeaderLen + PayloadLen);
    localparam logic [IdxW-1:0] IdxCrcHi   = IdxW'(FrameLen - 1);

    // payload bytes, byte 0 sent first (timestamp LSB)
    typedef logic [PayloadLen-1:0][7:0] t_payload;

    typedef struct packed {
        logic     valid;
        t_payload data;
    } t_q_head;

    // CRC-16, reflected poly, one byte per call
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/ssf_front.sv]
`timescale 1ns / 1ps
module ssf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [159:0]      i_s_axis_tdata,
    output logic              o_push,
    output ssf_pkg::t_payload o_push_data,
    input  logic              i_push_ready
);
    import ssf_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_payload r_data;
    logic     accept;

    assign o_s_axis_tready = !r_valid || i_push_ready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_push          = r_valid;
    assign o_push_data     = r_data;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // tdata is already little-endian field order: byte i is payload byte i
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= t_payload'(i_s_axis_tdata);
        end
    end

endmodule

[rtl/ssf_fifo.sv]
`timescale 1ns / 1ps
module ssf_fifo #(
    parameter int unsigned DEPTH = ssf_pkg::FifoDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ssf_pkg::t_payload i_push_data,
    output logic              o_push_ready,
    input  logic              i_pop,
    output ssf_pkg::t_q_head  o_head
);
    import ssf_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_payload            r_mem [DEPTH];
    logic [PtrW-1:0]     r_wr_ptr;
    logic [PtrW-1:0]     r_rd_ptr;
    logic [CntW-1:0]     r_count;
    logic [CntW-1:0]     n_count;
    logic                do_push;
    logic                do_pop;

    assign o_push_ready = (r_count != CntW'(DEPTH));
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CntW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

[rtl/ssf_back.sv]
`timescale 1ns / 1ps
module ssf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssf_pkg::t_q_head  i_head,
    output logic              o_pop,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [7:0]        o_m_axis_tdata,
    output logic              o_m_axis_tlast
);
    import ssf_pkg::*;

    logic [IdxW-1:0]    r_idx;
    logic [IdxW-1:0]    n_idx;
    logic [15:0]        r_crc;
    logic [15:0]        n_crc;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic               advance;
    logic               in_payload;
    logic [IdxW-1:0]    pay_off_full;
    logic [PayIdxW-1:0] pay_off;
    logic [7:0]         pay_byte;
    logic [7:0]         cur_byte;

    assign advance      = i_head.valid && (!r_out_valid || i_m_axis_tready);
    assign o_pop        = advance && (r_idx == IdxCrcHi);
    assign in_payload   = (r_idx >= IdxPayFirst) && (r_idx <= IdxPayLast);
    assign pay_off_full = r_idx - IdxPayFirst;
    assign pay_off      = in_payload ? pay_off_full[PayIdxW-1:0] : '0;
    assign pay_byte     = i_head.data[pay_off];

    always_comb begin
        case (r_idx)
            IdxSync0: cur_byte = SyncFirst;
            IdxSync1: cur_byte = SyncSecond;
            IdxLen:   cur_byte = LenByte;
            IdxCrcLo: cur_byte = r_crc[7:0];
            IdxCrcHi: cur_byte = r_crc[15:8];
            default:  cur_byte = pay_byte;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        n_crc = r_crc;
        if (advance) begin
            if (r_idx == IdxCrcHi) begin
                n_idx = '0;
                n_crc = CrcInit;
            end else begin
                n_idx = r_idx + IdxW'(1);
                if (in_payload) begin
                    n_crc = crc_byte(r_crc, pay_byte);
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_crc       <= CrcInit;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= cur_byte;
            r_out_last <= (r_idx == IdxCrcHi);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;

endmodule

[rtl/sensor_sample_framer_crc16_core.sv]
`timescale 1ns / 1ps
// Channel   Dir  Data                                              Side
// s_axis    in   tdata[159:0] one sample -> one frame request     front
// m_axis    out  tdata[7:0] frame byte, tlast on CRC high byte    back
//
// One sample yields 25 bytes: AA 55 14, 20 payload bytes, CRC low, CRC high.
// Back end emits one byte per cycle while a sample is queued and the sink holds
// tready high; a byte counter in the serializer walks the frame positions.
// Input stage plus queue hold up to FIFO_DEPTH+1 samples, the frame going out
// included (it stays at the queue head until its last byte); tready drops
// only when all are full.
// Reset (i_rst_n low, synchronous) empties the queue and output register.
module sensor_sample_framer_crc16_core #(
    parameter int unsigned FIFO_DEPTH = ssf_pkg::FifoDepth
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata, low bit up: timestamp[31:0], accel_x_val, accel_y_val,
    // accel_z_val, gyro_x_val, gyro_y_val, gyro_z_val, temperature_raw,
    // battery_raw (16 bits each)
    input  logic [159:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata: frame_byte[7:0]
    output logic [7:0]   o_m_axis_tdata,
    // tlast: last_byte
    output logic         o_m_axis_tlast
);
    import ssf_pkg::*;

    // front -> queue
    logic     push;
    t_payload push_data;
    logic     push_ready;
    // queue -> back
    t_q_head  head;
    logic     pop;

    // accept and hold one sample
    ssf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_push          (push),
        .o_push_data     (push_data),
        .i_push_ready    (push_ready)
    );

    // short sample queue decoupling intake from serialization
    ssf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_head       (head)
    );

    // byte serializer with running CRC; queue entry popped on the last byte
    ssf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
